/* hw/rtl/pal_pkg.sv */
package pal_pkg;

	// defaults for the top level parameters
	localparam int MAX_ENTRIES_DEF = 128;
	localparam int ENTRY_WIDTH_DEF = 64;

	// stream widths: fields packed from bit 0 and padded to whole bytes
	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 80;

	// field widths
	localparam int CMD_W    = 2;
	localparam int POS_W    = 8;
	localparam int DIN_W    = 64;
	localparam int STATUS_W = 2;
	localparam int DOUT_W   = 64;
	localparam int COUNT_W  = 8;

	// request operation codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INDEX = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic load_req;   // latch an accepted request
		logic stat_load;  // latch the checked status
		logic cur_init;   // start the shift cursor
		logic mem_rd;     // read one entry into the read register
		logic mem_wr_sh;  // write the read register one slot over, step cursor
		logic mem_wr_new; // write the new word at its slot, count up
		logic cnt_dec;    // count down after a delete
		logic out_load;   // load the result register
	} ctl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [STATUS_W-1:0] req_status; // check of the held request
		logic                is_insert;
		logic                is_read;
		logic                shift_done; // cursor reached the end of the shift
		logic                out_free;   // result register can take a new result
	} ctl_stat_t;

endpackage

/* hw/rtl/positional_array_list_unit.sv */
// channel   dir  tdata fields (low bit up)                        handshake
// s_*       in   cmd[1:0] position[9:2] entry_data[73:10], pad   tvalid/tready
// m_*       out  status[1:0] read_data[65:2] count[73:66], pad   tvalid/tready
//
// read and rejected requests go from the check state straight to the result state
// insert and delete step through the shift states, and insert then writes the new entry;
// the entry memory moves one entry per read then write pair
// reset clears the entry count and the controller; entries are not cleared
// a new request is taken once the previous result sits in the output register;
// a stalled output holds the controller before it loads the next result
module positional_array_list_unit #(
	parameter int MAX_ENTRIES = pal_pkg::MAX_ENTRIES_DEF,
	parameter int ENTRY_WIDTH = pal_pkg::ENTRY_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [pal_pkg::S_TDATA_W-1:0]   s_tdata, // cmd, position, entry_data
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pal_pkg::M_TDATA_W-1:0]   m_tdata  // status, read_data, count
);

	localparam int POS_LO = pal_pkg::CMD_W;
	localparam int DIN_LO = POS_LO + pal_pkg::POS_W;
	localparam int OUT_W  = pal_pkg::STATUS_W + pal_pkg::DOUT_W + pal_pkg::COUNT_W;

	pal_pkg::ctl_cmd_t  ctl_cmd;
	pal_pkg::ctl_stat_t ctl_stat;

	logic [pal_pkg::STATUS_W-1:0] out_status;
	logic [pal_pkg::DOUT_W-1:0]   out_read_data;
	logic [pal_pkg::COUNT_W-1:0]  out_count;

	// request sequencing
	pal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.stat      (ctl_stat),
		.cmd       (ctl_cmd)
	);

	// entry memory, count and result register
	pal_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_cmd        (s_tdata[pal_pkg::CMD_W-1:0]),
		.req_position   (s_tdata[DIN_LO-1:POS_LO]),
		.req_entry_data (s_tdata[DIN_LO+pal_pkg::DIN_W-1:DIN_LO]),
		.out_ready      (m_tready),
		.out_valid      (m_tvalid),
		.out_status     (out_status),
		.out_read_data  (out_read_data),
		.out_count      (out_count),
		.cmd            (ctl_cmd),
		.stat           (ctl_stat)
	);

	// result packing
	assign m_tdata = pal_pkg::M_TDATA_W'({out_count, out_read_data, out_status});

	// one request at a time: no accept right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while the previous one is in work");

	// only a successful read returns a nonzero word
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (out_read_data != '0) |-> out_status == pal_pkg::ST_OK)
		else $error("nonzero read data with a failing status");

	// a full rejection reports a full list
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_status == pal_pkg::ST_FULL
			|-> out_count == pal_pkg::COUNT_W'(MAX_ENTRIES))
		else $error("list full status with a count below capacity");

	// the entry memory is not written while the list is being checked
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.stat_load |-> !ctl_cmd.mem_wr_sh && !ctl_cmd.mem_wr_new)
		else $error("entry write during request check");

	// the output padding bits stay zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[pal_pkg::M_TDATA_W-1:OUT_W] == '0)
		else $error("nonzero pad bits on the result");

endmodule

/* hw/rtl/pal_ctrl.sv */
module pal_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  pal_pkg::ctl_stat_t stat,
	output pal_pkg::ctl_cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_EVAL   = 6'b000010,
		ST_SHIFT  = 6'b000100,
		ST_SH_WR  = 6'b001000,
		ST_WR_NEW = 6'b010000,
		ST_RESP   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign req_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_nxt    = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.stat_load = 1'b1;
				if (stat.req_status != pal_pkg::ST_OK) begin
					state_nxt = ST_RESP;
				end else if (stat.is_read) begin
					cmd.mem_rd = 1'b1;
					state_nxt  = ST_RESP;
				end else begin
					cmd.cur_init = 1'b1;
					state_nxt    = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (stat.shift_done) begin
					if (stat.is_insert) begin
						state_nxt = ST_WR_NEW;
					end else begin
						cmd.cnt_dec = 1'b1;
						state_nxt   = ST_RESP;
					end
				end else begin
					cmd.mem_rd = 1'b1;
					state_nxt  = ST_SH_WR;
				end
			end
			ST_SH_WR: begin
				cmd.mem_wr_sh = 1'b1;
				state_nxt     = ST_SHIFT;
			end
			ST_WR_NEW: begin
				cmd.mem_wr_new = 1'b1;
				state_nxt      = ST_RESP;
			end
			ST_RESP: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/pal_datapath.sv */
module pal_datapath #(
	parameter int MAX_ENTRIES = pal_pkg::MAX_ENTRIES_DEF,
	parameter int ENTRY_WIDTH = pal_pkg::ENTRY_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [pal_pkg::CMD_W-1:0]     req_cmd,
	input  logic [pal_pkg::POS_W-1:0]     req_position,
	input  logic [pal_pkg::DIN_W-1:0]     req_entry_data,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [pal_pkg::STATUS_W-1:0]  out_status,
	output logic [pal_pkg::DOUT_W-1:0]    out_read_data,
	output logic [pal_pkg::COUNT_W-1:0]   out_count,
	input  pal_pkg::ctl_cmd_t             cmd,
	output pal_pkg::ctl_stat_t            stat
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int AW    = $clog2(MAX_ENTRIES);
	localparam int PW    = ((CNT_W > pal_pkg::POS_W) ? CNT_W : pal_pkg::POS_W) + 1;

	// held request
	logic [pal_pkg::CMD_W-1:0]    cmd_q;
	logic [pal_pkg::POS_W-1:0]    pos_q;
	logic [ENTRY_WIDTH-1:0]       word_q;
	logic [pal_pkg::STATUS_W-1:0] stat_q;

	// list state
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       cur_q;
	logic [ENTRY_WIDTH-1:0] entries_q [MAX_ENTRIES];
	logic [ENTRY_WIDTH-1:0] rd_data_q;

	// result register
	logic                         out_valid_q;
	logic [pal_pkg::STATUS_W-1:0] out_status_q;
	logic [pal_pkg::DOUT_W-1:0]   out_rdata_q;
	logic [pal_pkg::COUNT_W-1:0]  out_count_q;

	logic [PW-1:0]             pos_ext;
	logic [PW-1:0]             cnt_ext;
	logic [CNT_W-1:0]          slot;
	logic [pal_pkg::STATUS_W-1:0] chk_status;
	logic                      is_insert;
	logic                      is_read;
	logic [AW-1:0]             rd_addr;
	logic [AW-1:0]             wr_addr;
	logic [ENTRY_WIDTH-1:0]    wr_data;
	logic                      wr_en;

	assign pos_ext   = PW'(pos_q);
	assign cnt_ext   = PW'(count_q);
	assign slot      = CNT_W'(pos_ext - PW'(1));
	assign is_insert = (cmd_q == pal_pkg::CMD_INSERT);
	assign is_read   = (cmd_q == pal_pkg::CMD_READ);

	// position and capacity check of the held request
	always_comb begin
		chk_status = pal_pkg::ST_OK;
		case (cmd_q)
			pal_pkg::CMD_INSERT: begin
				if (pos_q == '0 || pos_ext > cnt_ext + PW'(1)) begin
					chk_status = pal_pkg::ST_INDEX;
				end else if (count_q == CNT_W'(MAX_ENTRIES)) begin
					chk_status = pal_pkg::ST_FULL;
				end
			end
			pal_pkg::CMD_DELETE, pal_pkg::CMD_READ: begin
				if (pos_q == '0 || pos_ext > cnt_ext) begin
					chk_status = pal_pkg::ST_INDEX;
				end
			end
			default: begin
				chk_status = pal_pkg::ST_INDEX;
			end
		endcase
	end

	// status toward the controller
	always_comb begin
		stat.req_status = chk_status;
		stat.is_insert  = is_insert;
		stat.is_read    = is_read;
		stat.shift_done = is_insert ? (cur_q == slot) : (cur_q == count_q);
		stat.out_free   = !out_valid_q || out_ready;
	end

	// memory addresses: insert moves entries up, delete moves them down
	always_comb begin
		if (is_read) begin
			rd_addr = slot[AW-1:0];
		end else if (is_insert) begin
			rd_addr = AW'(cur_q - CNT_W'(1));
		end else begin
			rd_addr = cur_q[AW-1:0];
		end
		if (cmd.mem_wr_new) begin
			wr_addr = slot[AW-1:0];
			wr_data = word_q;
		end else begin
			wr_addr = is_insert ? cur_q[AW-1:0] : AW'(cur_q - CNT_W'(1));
			wr_data = rd_data_q;
		end
		wr_en = cmd.mem_wr_sh || cmd.mem_wr_new;
	end

	// entry memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entries_q[wr_addr] <= wr_data;
		end
		if (cmd.mem_rd) begin
			rd_data_q <= entries_q[rd_addr];
		end
	end

	// request, status and cursor registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			cmd_q  <= req_cmd;
			pos_q  <= req_position;
			word_q <= req_entry_data[ENTRY_WIDTH-1:0];
		end
		if (cmd.stat_load) begin
			stat_q <= chk_status;
		end
		if (cmd.cur_init) begin
			cur_q <= is_insert ? count_q : CNT_W'(pos_ext);
		end else if (cmd.mem_wr_sh) begin
			cur_q <= is_insert ? cur_q - CNT_W'(1) : cur_q + CNT_W'(1);
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.mem_wr_new) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= stat_q;
			out_count_q  <= pal_pkg::COUNT_W'(count_q);
			if (is_read && stat_q == pal_pkg::ST_OK) begin
				out_rdata_q <= pal_pkg::DOUT_W'(rd_data_q);
			end else begin
				out_rdata_q <= '0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_status    = out_status_q;
	assign out_read_data = out_rdata_q;
	assign out_count     = out_count_q;

endmodule
